FILE: rtl/palette_lookup_integer_scaler_assert.svh
// Assertion macros for the palette lookup scaler back end
`ifndef PALETTE_LOOKUP_INTEGER_SCALER_ASSERT_SVH
`define PALETTE_LOOKUP_INTEGER_SCALER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PLIS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define PLIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/plis_pkg.sv
// Package: constants, codes and shared types of the palette lookup scaler
`default_nettype none

package plis_pkg;

   // Source image and palette geometry
   localparam int SRC_WIDTH     = 320;
   localparam int SRC_HEIGHT    = 200;
   localparam int MAX_SCALE     = 8;
   localparam int PALETTE_DEPTH = 256;

   // Field widths
   localparam int IDX_W      = 8;
   localparam int RGB_W      = 24;
   localparam int ADDR_W     = 26;
   localparam int FB_W       = 12;
   localparam int PITCH_B_W  = 16;
   localparam int PITCH_W    = PITCH_B_W - 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Derived widths
   localparam int COL_W   = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
   localparam int ROW_W   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
   localparam int PAL_W   = $clog2(PALETTE_DEPTH);
   localparam int SCALE_W = $clog2(MAX_SCALE + 1);
   localparam int COORD_W = 16;

   // Queue depths (powers of two)
   localparam int JQ_DEPTH = 2;
   localparam int JQ_PTR_W = $clog2(JQ_DEPTH);
   localparam int JQ_CNT_W = $clog2(JQ_DEPTH + 1);
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   // Input commands
   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_PIXEL         = 1'b1;

   // Display modes
   localparam logic MODE_WINDOWED   = 1'b0;
   localparam logic MODE_FULLSCREEN = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PITCH_BYTES = 2'd3;

   // Register reset values
   localparam logic [FB_W-1:0]      RST_FRAME_WIDTH     = 12'd640;
   localparam logic [FB_W-1:0]      RST_FRAME_HEIGHT    = 12'd400;
   localparam logic [PITCH_B_W-1:0] RST_ROW_PITCH_BYTES = 16'd2560;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic                 display_mode;
      logic [FB_W-1:0]      frame_width;
      logic [FB_W-1:0]      frame_height;
      logic [PITCH_B_W-1:0] row_pitch_bytes;
   } cfg_type;

   // One classified pixel handed from front to back
   typedef struct packed {
      logic             fullscreen;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [RGB_W-1:0] rgb;
   } job_type;

   // One framebuffer write
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [RGB_W-1:0]  rgb;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/plis_front.sv
// Front end: accepts items, keeps the palette and the raster position, issues pixel jobs
`default_nettype none

module plis_front import plis_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             command,
   input  logic [IDX_W-1:0] entry_index,
   input  logic [RGB_W-1:0] entry_rgb,
   input  logic [IDX_W-1:0] color_index,
   input  logic             display_mode,
   output logic             job_valid,
   output job_type          job,
   input  logic             job_ready
);

   logic [RGB_W-1:0]         pal_mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_vld_ff;
   logic [RGB_W-1:0]         pal_rd_ff;
   logic                     pal_hit_ff;

   logic                     job_valid_ff;
   logic                     job_full_ff;
   logic [COL_W-1:0]         job_col_ff;
   logic [ROW_W-1:0]         job_row_ff;
   logic [COL_W-1:0]         col_ff;
   logic [ROW_W-1:0]         row_ff;

   logic accept;
   logic pix_acc;
   logic wr_acc;
   logic wr_in_range;
   logic rd_in_range;

   // Stall only while the issued job has not been taken
   assign full    = job_valid_ff && !job_ready;
   assign accept  = push && !full;
   assign pix_acc = accept && (command == CMD_PIXEL);

   assign wr_in_range = ({1'b0, entry_index} < (IDX_W + 1)'(PALETTE_DEPTH));
   assign rd_in_range = ({1'b0, color_index} < (IDX_W + 1)'(PALETTE_DEPTH));
   assign wr_acc      = accept && (command == CMD_PALETTE_WRITE) && wr_in_range;

   // Palette storage: write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_acc) begin
         pal_mem[entry_index[PAL_W-1:0]] <= entry_rgb;
      end
      if (pix_acc) begin
         pal_rd_ff <= pal_mem[color_index[PAL_W-1:0]];
      end
   end

   // Entry valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
         pal_hit_ff <= 1'b0;
      end else begin
         if (wr_acc) begin
            pal_vld_ff[entry_index[PAL_W-1:0]] <= 1'b1;
         end
         if (pix_acc) begin
            pal_hit_ff <= rd_in_range && pal_vld_ff[color_index[PAL_W-1:0]];
         end
      end
   end

   // Raster position: advance per pixel, wrap column then row
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (pix_acc) begin
         if (col_ff == COL_W'(SRC_WIDTH - 1)) begin
            col_ff <= '0;
            if (row_ff == ROW_W'(SRC_HEIGHT - 1)) begin
               row_ff <= '0;
            end else begin
               row_ff <= row_ff + ROW_W'(1);
            end
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // Job register: hold until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else if (pix_acc) begin
         job_valid_ff <= 1'b1;
      end else if (job_ready) begin
         job_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         job_full_ff <= (display_mode == MODE_FULLSCREEN);
         job_col_ff  <= col_ff;
         job_row_ff  <= row_ff;
      end
   end

   assign job_valid      = job_valid_ff;
   assign job.fullscreen = job_full_ff;
   assign job.col        = job_col_ff;
   assign job.row        = job_row_ff;
   assign job.rgb        = pal_hit_ff ? pal_rd_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/plis_job_queue.sv
// Short job queue between the front end and the write generator
`default_nettype none

module plis_job_queue import plis_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    push_ready,
   output logic    pop_valid,
   output job_type pop_job,
   input  logic    pop_ready
);

   job_type               jq_mem_ff [JQ_DEPTH];
   logic [JQ_PTR_W-1:0]   wr_ptr_ff;
   logic [JQ_PTR_W-1:0]   rd_ptr_ff;
   logic [JQ_CNT_W-1:0]   count_ff;

   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != JQ_CNT_W'(JQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = jq_mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         jq_mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + JQ_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + JQ_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + JQ_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - JQ_CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/plis_back.sv
// Back end: scale geometry, clip, write iteration, address multiply and result queue
`default_nettype none

`include "palette_lookup_integer_scaler_assert.svh"

module plis_back import plis_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              job_valid,
   input  job_type           job,
   output logic              job_ready,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [ADDR_W-1:0] rsp_write_address,
   output logic [RGB_W-1:0]  rsp_pixel_rgb,
   output logic              rsp_last_of_pixel
);

   // Geometry derived from the configuration
   logic [SCALE_W-1:0]        scale_ff;
   logic [SCALE_W-1:0]        scale_in;
   logic signed [COORD_W-1:0] fw_m1_ff;
   logic signed [COORD_W-1:0] fh_m1_ff;
   logic signed [COORD_W-1:0] offx_ff;
   logic signed [COORD_W-1:0] offy_ff;
   logic signed [COORD_W-1:0] offx_in;
   logic signed [COORD_W-1:0] offy_in;
   logic [PITCH_W-1:0]        pitch_ff;
   logic [COORD_W-1:0]        span_x;
   logic [COORD_W-1:0]        span_y;
   logic signed [COORD_W-1:0] diff_x;
   logic signed [COORD_W-1:0] diff_y;
   logic signed [COORD_W-1:0] half_x;
   logic signed [COORD_W-1:0] half_y;

   // Prep stage: block origin or linear address
   logic                      prep_valid_ff;
   logic                      prep_lin_ff;
   logic [ADDR_W-1:0]         prep_lin_addr_ff;
   logic signed [COORD_W-1:0] prep_x0_ff;
   logic signed [COORD_W-1:0] prep_y0_ff;
   logic [RGB_W-1:0]          prep_rgb_ff;
   logic [COORD_W-1:0]        prod_x;
   logic [COORD_W-1:0]        prod_y;
   logic                      prep_take;

   // Clip of the prep block
   logic signed [COORD_W-1:0] scale_m1;
   logic signed [COORD_W-1:0] xe_raw;
   logic signed [COORD_W-1:0] ye_raw;
   logic signed [COORD_W-1:0] xs_c;
   logic signed [COORD_W-1:0] xe_c;
   logic signed [COORD_W-1:0] ys_c;
   logic signed [COORD_W-1:0] ye_c;
   logic                      clip_empty;
   logic                      it_load;

   // Write iterator
   logic                      it_busy_ff;
   logic [FB_W-1:0]           it_x_ff;
   logic [FB_W-1:0]           it_y_ff;
   logic [FB_W-1:0]           it_xs_ff;
   logic [FB_W-1:0]           it_xe_ff;
   logic [FB_W-1:0]           it_ye_ff;
   logic                      it_lin_ff;
   logic [ADDR_W-1:0]         it_lin_addr_ff;
   logic [RGB_W-1:0]          it_rgb_ff;
   logic                      it_last;
   logic                      it_step;
   logic                      room;

   // Address stage
   logic                      a_valid_ff;
   logic [FB_W-1:0]           a_x_ff;
   logic [FB_W-1:0]           a_y_ff;
   logic                      a_lin_ff;
   logic [ADDR_W-1:0]         a_lin_addr_ff;
   logic [RGB_W-1:0]          a_rgb_ff;
   logic                      a_last_ff;
   logic [ADDR_W-1:0]         fb_addr;
   rsp_type                   rsp_in;

   // Result queue
   rsp_type                   rq_mem_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]       rq_wr_ptr_ff;
   logic [RQ_PTR_W-1:0]       rq_rd_ptr_ff;
   logic [RQ_CNT_W-1:0]       rq_count_ff;
   logic                      rq_pop;

   // Scale: largest factor that fits both dimensions, at least one
   always_comb begin
      scale_in = SCALE_W'(1);
      for (int k = 1; k <= MAX_SCALE; k++) begin
         if ((32'(cfg.frame_width) >= 32'(SRC_WIDTH * k)) &&
             (32'(cfg.frame_height) >= 32'(SRC_HEIGHT * k))) begin
            scale_in = SCALE_W'(k);
         end
      end
   end

   // Centering offsets, halved with truncation toward zero
   always_comb begin
      span_x  = COORD_W'(SRC_WIDTH) * COORD_W'(scale_ff);
      span_y  = COORD_W'(SRC_HEIGHT) * COORD_W'(scale_ff);
      diff_x  = $signed(COORD_W'(cfg.frame_width)) - $signed(span_x);
      diff_y  = $signed(COORD_W'(cfg.frame_height)) - $signed(span_y);
      half_x  = diff_x + $signed({{(COORD_W - 1){1'b0}}, diff_x[COORD_W-1]});
      half_y  = diff_y + $signed({{(COORD_W - 1){1'b0}}, diff_y[COORD_W-1]});
      offx_in = half_x >>> 1;
      offy_in = half_y >>> 1;
   end

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
      offx_ff  <= offx_in;
      offy_ff  <= offy_in;
      fw_m1_ff <= $signed(COORD_W'(cfg.frame_width)) - $signed(COORD_W'(1));
      fh_m1_ff <= $signed(COORD_W'(cfg.frame_height)) - $signed(COORD_W'(1));
      pitch_ff <= cfg.row_pitch_bytes[PITCH_B_W-1:2];
   end

   // Prep: take a job when the stage is free or handing over
   assign job_ready = !prep_valid_ff || prep_take;
   assign prod_x    = COORD_W'(job.col) * COORD_W'(scale_ff);
   assign prod_y    = COORD_W'(job.row) * COORD_W'(scale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (job_valid && job_ready) begin
         prep_valid_ff <= 1'b1;
      end else if (prep_take) begin
         prep_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         prep_lin_ff      <= !job.fullscreen;
         prep_lin_addr_ff <= ADDR_W'(job.row) * ADDR_W'(SRC_WIDTH) + ADDR_W'(job.col);
         prep_x0_ff       <= offx_ff + $signed(prod_x);
         prep_y0_ff       <= offy_ff + $signed(prod_y);
         prep_rgb_ff      <= job.rgb;
      end
   end

   // Clip the block against the framebuffer
   always_comb begin
      scale_m1 = $signed(COORD_W'(scale_ff)) - $signed(COORD_W'(1));
      xe_raw   = prep_x0_ff + scale_m1;
      ye_raw   = prep_y0_ff + scale_m1;
      xs_c     = prep_x0_ff[COORD_W-1] ? '0 : prep_x0_ff;
      ys_c     = prep_y0_ff[COORD_W-1] ? '0 : prep_y0_ff;
      xe_c     = (xe_raw < fw_m1_ff) ? xe_raw : fw_m1_ff;
      ye_c     = (ye_raw < fh_m1_ff) ? ye_raw : fh_m1_ff;
      if (prep_lin_ff) begin
         xs_c = '0;
         xe_c = '0;
         ys_c = '0;
         ye_c = '0;
      end
      clip_empty = (xs_c > xe_c) || (ys_c > ye_c);
   end

   // Iterator: one kept write per cycle while the result queue has room
   assign room    = (({1'b0, rq_count_ff} + (RQ_CNT_W + 1)'(a_valid_ff))
                     < (RQ_CNT_W + 1)'(RQ_DEPTH));
   assign it_step = it_busy_ff && room;
   assign it_last = (it_x_ff == it_xe_ff) && (it_y_ff == it_ye_ff);

   assign prep_take = prep_valid_ff && (!it_busy_ff || (it_step && it_last));
   assign it_load   = prep_take && !clip_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         it_busy_ff <= 1'b0;
      end else if (it_load) begin
         it_busy_ff <= 1'b1;
      end else if (it_step && it_last) begin
         it_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (it_load) begin
         it_x_ff        <= FB_W'(xs_c);
         it_y_ff        <= FB_W'(ys_c);
         it_xs_ff       <= FB_W'(xs_c);
         it_xe_ff       <= FB_W'(xe_c);
         it_ye_ff       <= FB_W'(ye_c);
         it_lin_ff      <= prep_lin_ff;
         it_lin_addr_ff <= prep_lin_addr_ff;
         it_rgb_ff      <= prep_rgb_ff;
      end else if (it_step && !it_last) begin
         if (it_x_ff == it_xe_ff) begin
            it_x_ff <= it_xs_ff;
            it_y_ff <= it_y_ff + FB_W'(1);
         end else begin
            it_x_ff <= it_x_ff + FB_W'(1);
         end
      end
   end

   // Address stage: hold one beat for the row multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= it_step;
      end
   end

   always_ff @(posedge clock) begin
      if (it_step) begin
         a_x_ff        <= it_x_ff;
         a_y_ff        <= it_y_ff;
         a_lin_ff      <= it_lin_ff;
         a_lin_addr_ff <= it_lin_addr_ff;
         a_rgb_ff      <= it_rgb_ff;
         a_last_ff     <= it_last;
      end
   end

   assign fb_addr     = ADDR_W'(a_y_ff) * ADDR_W'(pitch_ff) + ADDR_W'(a_x_ff);
   assign rsp_in.addr = a_lin_ff ? a_lin_addr_ff : fb_addr;
   assign rsp_in.rgb  = a_rgb_ff;
   assign rsp_in.last = a_last_ff;

   // Result queue storage
   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         rq_mem_ff[rq_wr_ptr_ff] <= rsp_in;
      end
   end

   assign rsp_empty = (rq_count_ff == '0);
   assign rq_pop    = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ptr_ff <= '0;
         rq_rd_ptr_ff <= '0;
         rq_count_ff  <= '0;
      end else begin
         if (a_valid_ff) begin
            rq_wr_ptr_ff <= rq_wr_ptr_ff + RQ_PTR_W'(1);
         end
         if (rq_pop) begin
            rq_rd_ptr_ff <= rq_rd_ptr_ff + RQ_PTR_W'(1);
         end
         if (a_valid_ff && !rq_pop) begin
            rq_count_ff <= rq_count_ff + RQ_CNT_W'(1);
         end else if (rq_pop && !a_valid_ff) begin
            rq_count_ff <= rq_count_ff - RQ_CNT_W'(1);
         end
      end
   end

   assign rsp_write_address = rq_mem_ff[rq_rd_ptr_ff].addr;
   assign rsp_pixel_rgb     = rq_mem_ff[rq_rd_ptr_ff].rgb;
   assign rsp_last_of_pixel = rq_mem_ff[rq_rd_ptr_ff].last;

   // Iterator stays inside its clipped rectangle
   `PLIS_ASSERT_IMPL(a_iter_in_rect, clock, reset, it_busy_ff, (it_x_ff <= it_xe_ff) && (it_y_ff <= it_ye_ff))
   // Credit check: a beat in the address stage always finds a free slot
   `PLIS_ASSERT_IMPL(a_rq_has_slot, clock, reset, a_valid_ff, rq_count_ff < RQ_CNT_W'(RQ_DEPTH))
   // A windowed pixel loads as a single-beat block
   `PLIS_ASSERT_NEXT(a_win_one_beat, clock, reset, it_load && prep_lin_ff, it_busy_ff && (it_x_ff == it_xe_ff) && (it_y_ff == it_ye_ff))

endmodule

`default_nettype wire

FILE: rtl/palette_lookup_integer_scaler.sv
// Path: front job register, job queue, prep, write iterator, address stage, result queue.
// The iterator issues one write per cycle while the result queue has room; a windowed
//   pixel makes one write, a fullscreen one per kept write (scale*scale, 4 at scale two).
// Palette writes are accepted at one per cycle while full is low and produce no result.
// Reset (synchronous, active high): queues empty, raster position zero, every palette
//   entry reads as zero, registers return to windowed 640x400 with a 2560-byte pitch.
`default_nettype none

module palette_lookup_integer_scaler import plis_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  push,
   output logic                  full,
   input  logic                  req_command,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic [RGB_W-1:0]      req_entry_rgb,
   input  logic [IDX_W-1:0]      req_color_index,
   // Result channel
   output logic                  empty,
   input  logic                  pop,
   output logic [ADDR_W-1:0]     rsp_write_address,
   output logic [RGB_W-1:0]      rsp_pixel_rgb,
   output logic                  rsp_last_of_pixel,
   // Configuration port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                 mode_ff;
   logic [FB_W-1:0]      frame_width_ff;
   logic [FB_W-1:0]      frame_height_ff;
   logic [PITCH_B_W-1:0] pitch_bytes_ff;
   cfg_type              cfg;

   logic                 fe_job_valid;
   job_type              fe_job;
   logic                 fe_job_ready;
   logic                 be_job_valid;
   job_type              be_job;
   logic                 be_job_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_WINDOWED;
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         pitch_bytes_ff  <= RST_ROW_PITCH_BYTES;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DISPLAY_MODE:    mode_ff         <= csr_wdata[0];
            CSR_FRAME_WIDTH:     frame_width_ff  <= csr_wdata[FB_W-1:0];
            CSR_FRAME_HEIGHT:    frame_height_ff <= csr_wdata[FB_W-1:0];
            CSR_ROW_PITCH_BYTES: pitch_bytes_ff  <= csr_wdata[PITCH_B_W-1:0];
         endcase
      end
   end

   assign cfg.display_mode    = mode_ff;
   assign cfg.frame_width     = frame_width_ff;
   assign cfg.frame_height    = frame_height_ff;
   assign cfg.row_pitch_bytes = pitch_bytes_ff;

   plis_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .command      (req_command),
      .entry_index  (req_entry_index),
      .entry_rgb    (req_entry_rgb),
      .color_index  (req_color_index),
      .display_mode (cfg.display_mode),
      .job_valid    (fe_job_valid),
      .job          (fe_job),
      .job_ready    (fe_job_ready)
   );

   plis_job_queue u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fe_job_valid),
      .push_job   (fe_job),
      .push_ready (fe_job_ready),
      .pop_valid  (be_job_valid),
      .pop_job    (be_job),
      .pop_ready  (be_job_ready)
   );

   plis_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .job_valid         (be_job_valid),
      .job               (be_job),
      .job_ready         (be_job_ready),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_rgb     (rsp_pixel_rgb),
      .rsp_last_of_pixel (rsp_last_of_pixel)
   );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the palette lookup integer scaler
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import plis_pkg::*;

   localparam int SETTLE_CYCLES    = 32;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int MAX_REPORTS      = 40;
   localparam int RANDOM_ITEMS     = 350;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_command;
   logic [IDX_W-1:0]      req_entry_index;
   logic [RGB_W-1:0]      req_entry_rgb;
   logic [IDX_W-1:0]      req_color_index;
   logic                  empty;
   logic                  pop;
   logic [ADDR_W-1:0]     rsp_write_address;
   logic [RGB_W-1:0]      rsp_pixel_rgb;
   logic                  rsp_last_of_pixel;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the block state
   logic [RGB_W-1:0] shadow_palette [PALETTE_DEPTH];
   cfg_type          shadow_cfg;
   int unsigned      raster_col;
   int unsigned      raster_row;
   int unsigned      rows_done;
   rsp_type          pending_writes[$];

   // Run statistics
   int items_sent;
   int pixels_sent;
   int writes_checked;
   int mismatch_count;
   int register_writes;
   int full_cycles;
   int max_writes_per_pixel;
   int idle_cycles;

   // Traffic shaping for the send tasks and the pop process
   bit input_steady;
   bit output_steady;
   bit hold_request;
   int send_calm;

   palette_lookup_integer_scaler dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_entry_rgb     (req_entry_rgb),
      .req_color_index   (req_color_index),
      .empty             (empty),
      .pop               (pop),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_rgb     (rsp_pixel_rgb),
      .rsp_last_of_pixel (rsp_last_of_pixel),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pick an idle length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Predict the framebuffer writes of one pixel at the current raster position
   task automatic predict_pixel(input logic [IDX_W-1:0] cidx);
      logic [RGB_W-1:0] color;
      int               fw, fh, scale, offx, offy, x, y, dx, dy, kept;
      int unsigned      pitch;
      rsp_type          w;
      rsp_type          prev;
      bit               have_prev;
      color = (int'(cidx) < PALETTE_DEPTH) ? shadow_palette[cidx] : '0;
      kept = 0;
      have_prev = 1'b0;
      if (shadow_cfg.display_mode == MODE_WINDOWED) begin
         prev.addr = ADDR_W'(raster_row * SRC_WIDTH + raster_col);
         prev.rgb  = color;
         have_prev = 1'b1;
         kept = 1;
      end else begin
         fw = int'(shadow_cfg.frame_width);
         fh = int'(shadow_cfg.frame_height);
         scale = (fw / SRC_WIDTH < fh / SRC_HEIGHT) ? fw / SRC_WIDTH : fh / SRC_HEIGHT;
         if (scale < 1) scale = 1;
         if (scale > MAX_SCALE) scale = MAX_SCALE;
         // centering offsets truncate toward zero and may be negative
         offx = (fw - SRC_WIDTH * scale) / 2;
         offy = (fh - SRC_HEIGHT * scale) / 2;
         pitch = int'(shadow_cfg.row_pitch_bytes) >> 2;
         for (dy = 0; dy < scale; dy++) begin
            y = offy + int'(raster_row) * scale + dy;
            if (y < 0 || y >= fh) continue;
            for (dx = 0; dx < scale; dx++) begin
               x = offx + int'(raster_col) * scale + dx;
               if (x < 0 || x >= fw) continue;
               w.addr = ADDR_W'(unsigned'(y) * pitch + unsigned'(x));
               w.rgb  = color;
               w.last = 1'b0;
               // hold back one write so the last kept one can be flagged
               if (have_prev) pending_writes.push_back(prev);
               prev = w;
               have_prev = 1'b1;
               kept++;
            end
         end
      end
      if (have_prev) begin
         prev.last = 1'b1;
         pending_writes.push_back(prev);
      end
      if (kept > max_writes_per_pixel) max_writes_per_pixel = kept;
   endtask

   task automatic advance_raster();
      raster_col++;
      if (raster_col >= SRC_WIDTH) begin
         raster_col = 0;
         rows_done++;
         raster_row++;
         if (raster_row >= SRC_HEIGHT) begin
            raster_row = 0;
         end
      end
   endtask

   task automatic apply_register_write(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] data);
      register_writes++;
      case (idx)
         CSR_DISPLAY_MODE:    shadow_cfg.display_mode    = data[0];
         CSR_FRAME_WIDTH:     shadow_cfg.frame_width     = data[FB_W-1:0];
         CSR_FRAME_HEIGHT:    shadow_cfg.frame_height    = data[FB_W-1:0];
         CSR_ROW_PITCH_BYTES: shadow_cfg.row_pitch_bytes = data[PITCH_B_W-1:0];
         default: ;
      endcase
   endtask

   task automatic check_write();
      rsp_type want;
      if (pending_writes.size() == 0) begin
         report_mismatch($sformatf("unexpected write addr=%h rgb=%h last=%b",
                                   rsp_write_address, rsp_pixel_rgb, rsp_last_of_pixel));
      end else begin
         want = pending_writes.pop_front();
         writes_checked++;
         if (rsp_write_address !== want.addr || rsp_pixel_rgb !== want.rgb ||
             rsp_last_of_pixel !== want.last)
            report_mismatch($sformatf(
               "write %0d got addr=%h rgb=%h last=%b, want addr=%h rgb=%h last=%b",
               writes_checked, rsp_write_address, rsp_pixel_rgb, rsp_last_of_pixel,
               want.addr, want.rgb, want.last));
      end
   endtask

   // Track every beat on the three ports at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg.display_mode    = MODE_WINDOWED;
         shadow_cfg.frame_width     = RST_FRAME_WIDTH;
         shadow_cfg.frame_height    = RST_FRAME_HEIGHT;
         shadow_cfg.row_pitch_bytes = RST_ROW_PITCH_BYTES;
         foreach (shadow_palette[i]) shadow_palette[i] = '0;
         raster_col = 0;
         raster_row = 0;
      end else begin
         if (csr_wr_en) apply_register_write(csr_index, csr_wdata);
         if (pop && !empty) check_write();
         if (push && full) full_cycles++;
         if (push && !full) begin
            items_sent++;
            if (req_command == CMD_PALETTE_WRITE) begin
               if (int'(req_entry_index) < PALETTE_DEPTH)
                  shadow_palette[req_entry_index] = req_entry_rgb;
            end else begin
               pixels_sent++;
               predict_pixel(req_color_index);
               advance_raster();
            end
         end
      end
   end

   // End the run when no beat moves on any port for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || csr_wr_en) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d writes outstanding",
                     idle_cycles, pending_writes.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Drive pop: random stalls, calm stretches, and one long hold on request
   initial begin
      int gap;
      int pop_stall_left;
      int pop_calm;
      pop = 1'b0;
      pop_stall_left = 0;
      pop_calm = 0;
      forever begin
         @(negedge clock);
         if (reset) begin
            pop = 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            pop = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (pop_stall_left > 0) begin
            pop = 1'b0;
            pop_stall_left--;
         end else if (output_steady) begin
            pop = 1'b1;
         end else begin
            gap = pick_gap(pop_calm);
            pop = (gap == 0);
            pop_stall_left = (gap > 0) ? gap - 1 : 0;
         end
      end
   end

   // Offer one item until accepted, then idle at random; push stays high when no gap
   task automatic send_item(input logic cmd, input logic [IDX_W-1:0] eidx,
                            input logic [RGB_W-1:0] ergb, input logic [IDX_W-1:0] cidx);
      int gap;
      push            = 1'b1;
      req_command     = cmd;
      req_entry_index = eidx;
      req_entry_rgb   = ergb;
      req_color_index = cidx;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
      gap = input_steady ? 0 : pick_gap(send_calm);
      if (gap > 0) begin
         push = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_pixel(input logic [IDX_W-1:0] cidx);
      send_item(CMD_PIXEL, IDX_W'($urandom), RGB_W'($urandom), cidx);
   endtask

   task automatic send_palette(input logic [IDX_W-1:0] eidx, input logic [RGB_W-1:0] ergb);
      send_item(CMD_PALETTE_WRITE, eidx, ergb, IDX_W'($urandom));
   endtask

   task automatic send_random_items(input int count, input int palette_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < palette_pct)
            send_palette(IDX_W'($urandom), RGB_W'($urandom));
         else
            send_pixel(IDX_W'($urandom));
      end
   endtask

   // Stop offering, wait for every expected write, then let a clipped pixel finish
   task automatic drain_results();
      push = 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write one register; bits above its width carry noise the block must ignore
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      int                    width;
      logic [CSR_DATA_W-1:0] data;
      case (idx)
         CSR_DISPLAY_MODE:    width = 1;
         CSR_FRAME_WIDTH:     width = FB_W;
         CSR_FRAME_HEIGHT:    width = FB_W;
         default:             width = PITCH_B_W;
      endcase
      data = CSR_DATA_W'(value);
      if (width < CSR_DATA_W) data = data | (CSR_DATA_W'($urandom) << width);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic configure(input logic mode, input int unsigned fw, input int unsigned fh,
                            input int unsigned pitch_bytes);
      drain_results();
      write_register(CSR_DISPLAY_MODE, mode);
      write_register(CSR_FRAME_WIDTH, fw);
      write_register(CSR_FRAME_HEIGHT, fh);
      write_register(CSR_ROW_PITCH_BYTES, pitch_bytes);
   endtask

   // Windowed output from the reset palette, extreme entries and overwrites
   task automatic test_palette_directed();
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_palette(8'd0, 24'hFFFFFF);
      send_palette(8'd255, 24'h800001);
      send_palette(8'd128, 24'h000000);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd77);
      send_palette(8'd0, 24'h5AA5C3);
      send_pixel(8'd0);
   endtask

   // Switch modes between pixels; position carries on
   task automatic test_mode_switch();
      drain_results();
      write_register(CSR_DISPLAY_MODE, MODE_FULLSCREEN);
      send_pixel(8'd255);
      send_pixel(8'd0);
      drain_results();
      write_register(CSR_DISPLAY_MODE, MODE_WINDOWED);
      send_pixel(8'd128);
   endtask

   // Geometry extremes: saturated scale, full clipping, truncated offsets, odd pitch
   task automatic test_geometry();
      configure(MODE_FULLSCREEN, 4095, 4095, 65535);
      send_random_items(2, 0);
      configure(MODE_FULLSCREEN, 2880, 1600, 11520);
      send_random_items(2, 0);
      configure(MODE_FULLSCREEN, 0, 0, 0);
      send_random_items(2, 0);
      configure(MODE_FULLSCREEN, 319, 199, 1276);
      send_random_items(2, 0);
      configure(MODE_FULLSCREEN, 2000, 1000, 8003);
      send_random_items(2, 0);
      configure(MODE_WINDOWED, 4095, 0, 65535);
      send_random_items(2, 0);
   endtask

   // Hold pop off for a long stretch while pixels keep coming, so the input stalls
   task automatic test_backpressure();
      configure(MODE_FULLSCREEN, 640, 400, 2560);
      hold_request = 1'b1;
      input_steady = 1'b1;
      send_random_items(40, 10);
      input_steady = 1'b0;
      drain_results();
   endtask

   // Random register settings, each followed by a burst of random items
   task automatic test_random();
      int          sent;
      int          burst;
      int unsigned fw, fh, pitch_bytes;
      logic        mode;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mode = ($urandom_range(0, 99) < 75) ? MODE_FULLSCREEN : MODE_WINDOWED;
         case ($urandom_range(0, 9))
            0, 1:    fw = $urandom_range(0, 400);
            2:       fw = $urandom_range(0, 4095);
            default: fw = $urandom_range(200, 1400);
         endcase
         case ($urandom_range(0, 9))
            0, 1:    fh = $urandom_range(0, 250);
            2:       fh = $urandom_range(0, 4095);
            default: fh = $urandom_range(100, 900);
         endcase
         if ($urandom_range(0, 9) < 7)
            pitch_bytes = (fw * 4 + $urandom_range(0, 7)) & 16'hFFFF;
         else
            pitch_bytes = $urandom_range(0, 65535);
         configure(mode, fw, fh, pitch_bytes);
         burst = $urandom_range(20, 60);
         send_random_items(burst, 25);
         sent += burst;
      end
   endtask

   // Stream at least 16 pixels back to back, more until the run has sent SRC_WIDTH + 16 pixels
   task automatic test_row_wrap();
      configure(MODE_WINDOWED, 640, 400, 2560);
      input_steady = 1'b1;
      output_steady = 1'b1;
      repeat (16) send_pixel(IDX_W'($urandom));
      while (pixels_sent < SRC_WIDTH + 16) send_pixel(IDX_W'($urandom));
      input_steady = 1'b0;
      output_steady = 1'b0;
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_command = CMD_PALETTE_WRITE;
      req_entry_index = '0;
      req_entry_rgb = '0;
      req_color_index = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_DISPLAY_MODE;
      csr_wdata = '0;
      input_steady = 1'b0;
      output_steady = 1'b0;
      hold_request = 1'b0;
      send_calm = 0;
      items_sent = 0;
      pixels_sent = 0;
      writes_checked = 0;
      mismatch_count = 0;
      register_writes = 0;
      full_cycles = 0;
      max_writes_per_pixel = 0;
      idle_cycles = 0;
      rows_done = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_palette_directed();
      test_mode_switch();
      test_geometry();
      test_backpressure();
      test_random();
      test_row_wrap();
      drain_results();

      $display("Covered %0d items (%0d pixels, %0d source rows completed), %0d writes checked,",
               items_sent, pixels_sent, rows_done, writes_checked);
      $display("%0d register writes, up to %0d writes per pixel, %0d input stall cycles",
               register_writes, max_writes_per_pixel, full_cycles);
      if (mismatch_count == 0 && pending_writes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: palette_lookup_integer_scaler.f
+incdir+rtl
rtl/plis_pkg.sv
rtl/plis_front.sv
rtl/plis_job_queue.sv
rtl/plis_back.sv
rtl/palette_lookup_integer_scaler.sv
dv/testbench.sv
